### design/sptp_pkg.sv
// Shared constants and tables for the screen point to pan/tilt servo block.
// No dependencies.
package sptp_pkg;

  localparam int unsigned CW     = 46;  // CORDIC x/y datapath width
  localparam int unsigned ZW     = 27;  // angle accumulator, Q.24 radians
  localparam int unsigned R2W    = 33;  // x^2 + D^2
  localparam int unsigned SQ_N   = 25;  // result bits of the square root
  localparam int unsigned REMW   = 28;
  localparam int unsigned ANGW   = 17;  // Q2.14 angle
  localparam int unsigned PRODW  = 34;
  localparam int unsigned POSW   = 15;
  localparam int unsigned CNTW   = 12;
  localparam int unsigned SCLW   = 16;
  localparam int unsigned CFG_IDXW = 3;

  typedef enum logic [CFG_IDXW-1:0] {
    REG_PAN_ORIGIN  = 3'd0,
    REG_TILT_ORIGIN = 3'd1,
    REG_PAN_SCALE   = 3'd2,
    REG_TILT_SCALE  = 3'd3,
    REG_PAN_MIN     = 3'd4,
    REG_PAN_MAX     = 3'd5,
    REG_TILT_MIN    = 3'd6,
    REG_TILT_MAX    = 3'd7
  } cfg_reg_e;

  // atan(2^-i) in Q.24 radians, rounded to nearest
  function automatic logic [ZW-1:0] atan_q24(input int unsigned i);
    logic [ZW-1:0] r;
    case (i)
      0:  r = 27'd13176795;
      1:  r = 27'd7778716;
      2:  r = 27'd4110060;
      3:  r = 27'd2086331;
      4:  r = 27'd1047214;
      5:  r = 27'd524117;
      6:  r = 27'd262123;
      7:  r = 27'd131069;
      8:  r = 27'd65536;
      9:  r = 27'd32768;
      10: r = 27'd16384;
      11: r = 27'd8192;
      12: r = 27'd4096;
      13: r = 27'd2048;
      14: r = 27'd1024;
      15: r = 27'd512;
      16: r = 27'd256;
      17: r = 27'd128;
      18: r = 27'd64;
      19: r = 27'd32;
      20: r = 27'd16;
      21: r = 27'd8;
      22: r = 27'd4;
      23: r = 27'd2;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

### design/screen_point_to_pan_tilt_servo.sv
// Screen point to pan/tilt servo counts: square root, dual vectoring CORDIC,
// scaling and clamping in one pipeline. Uses sptp_pkg.
//
// Usage:
//   s_axis: one beat per target point, tdata = {target_y, target_x}.
//   m_axis: one beat per point, tdata = {pad, clamp_flags, tilt_count,
//           pan_count}.
//   cfg: write enable, register index and data; write only while idle.
// Pipeline: 1 input stage + 1 squaring stage + 25 square root stages (one
// result bit each) + 1 CORDIC load stage + CORDIC_STAGES rotation stages +
// multiply stage + output register.
// Throughput: one point per cycle while the output beat is not held; the square
// root bit stages and the CORDIC rotation stages each carry a different point.
// Stall: all stages share one advance enable; while the output beat is held
// and not taken the pipeline freezes and s_axis_tready drops, nothing lost.
// Reset: clears all valid bits and loads the register defaults (origins
// 2048, scales 41728, limits 0..4095).
module screen_point_to_pan_tilt_servo #(
  parameter int unsigned SCREEN_DIST   = 1000,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [15:0] target_x, [31:16] target_y
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [11:0] pan_count, [23:12] tilt_count,
                                      // [25:24] clamp_flags, [31:26] zero
  input  logic        cfg_we_i,
  input  logic [sptp_pkg::CFG_IDXW-1:0] cfg_idx_i,
  input  logic [sptp_pkg::SCLW-1:0]     cfg_data_i
);

  localparam int unsigned CW   = sptp_pkg::CW;
  localparam int unsigned ZW   = sptp_pkg::ZW;
  localparam int unsigned NSQ  = sptp_pkg::SQ_N;
  localparam int unsigned NCO  = CORDIC_STAGES;
  localparam logic [15:0] DIST = 16'(SCREEN_DIST);
  localparam logic [sptp_pkg::R2W-1:0] DD = sptp_pkg::R2W'(SCREEN_DIST * SCREEN_DIST);

  // configuration registers
  logic [11:0] pan_origin_q, tilt_origin_q, pan_min_q, pan_max_q, tilt_min_q, tilt_max_q;
  logic [15:0] pan_scale_q, tilt_scale_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pan_origin_q  <= 12'd2048;
      tilt_origin_q <= 12'd2048;
      pan_scale_q   <= 16'd41728;
      tilt_scale_q  <= 16'd41728;
      pan_min_q     <= 12'd0;
      pan_max_q     <= 12'd4095;
      tilt_min_q    <= 12'd0;
      tilt_max_q    <= 12'd4095;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sptp_pkg::REG_PAN_ORIGIN:  pan_origin_q  <= cfg_data_i[11:0];
        sptp_pkg::REG_TILT_ORIGIN: tilt_origin_q <= cfg_data_i[11:0];
        sptp_pkg::REG_PAN_SCALE:   pan_scale_q   <= cfg_data_i;
        sptp_pkg::REG_TILT_SCALE:  tilt_scale_q  <= cfg_data_i;
        sptp_pkg::REG_PAN_MIN:     pan_min_q     <= cfg_data_i[11:0];
        sptp_pkg::REG_PAN_MAX:     pan_max_q     <= cfg_data_i[11:0];
        sptp_pkg::REG_TILT_MIN:    tilt_min_q    <= cfg_data_i[11:0];
        sptp_pkg::REG_TILT_MAX:    tilt_max_q    <= cfg_data_i[11:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // input stage
  logic              in_vld_q;
  logic signed [15:0] in_x_q, in_y_q;

  // square root stages: index k holds the state entering bit stage k
  logic                          sq_vld_q [NSQ+1];
  logic [sptp_pkg::R2W-1:0]      sq_r2_q  [NSQ+1];
  logic [sptp_pkg::REMW-1:0]     sq_rem_q [NSQ+1];
  logic [NSQ-1:0]                sq_q_q   [NSQ+1];
  logic signed [15:0]            sq_x_q   [NSQ+1];
  logic signed [15:0]            sq_y_q   [NSQ+1];
  logic [sptp_pkg::REMW-1:0]     sq_rem_d [NSQ];
  logic [NSQ-1:0]                sq_q_d   [NSQ];

  // CORDIC stages: index i holds the vectors entering rotation i
  logic                  co_vld_q [NCO+1];
  logic signed [CW-1:0]  px_q [NCO+1], py_q [NCO+1], tx_q [NCO+1], ty_q [NCO+1];
  logic signed [ZW-1:0]  pz_q [NCO+1], tz_q [NCO+1];
  logic signed [CW-1:0]  px_d [NCO], py_d [NCO], tx_d [NCO], ty_d [NCO];
  logic signed [ZW-1:0]  pz_d [NCO], tz_d [NCO];

  genvar k;
  generate
    for (k = 0; k < NSQ; k++) begin : g_sqrt
      logic [49:0]               v;
      logic [sptp_pkg::REMW-1:0] remsh, trial;
      always_comb begin
        v     = {1'b0, sq_r2_q[k], 16'b0};
        remsh = {sq_rem_q[k][sptp_pkg::REMW-3:0], v[49-2*k -: 2]};
        trial = {2'b0, sq_q_q[k][NSQ-2:0], 2'b01};
        if (remsh >= trial) begin
          sq_rem_d[k] = remsh - trial;
          sq_q_d[k]   = {sq_q_q[k][NSQ-2:0], 1'b1};
        end else begin
          sq_rem_d[k] = remsh;
          sq_q_d[k]   = {sq_q_q[k][NSQ-2:0], 1'b0};
        end
      end
    end

    for (k = 0; k < NCO; k++) begin : g_cordic
      logic [ZW-1:0] a;
      assign a = sptp_pkg::atan_q24(k);
      always_comb begin
        if (!py_q[k][CW-1]) begin
          px_d[k] = px_q[k] + (py_q[k] >>> k);
          py_d[k] = py_q[k] - (px_q[k] >>> k);
          pz_d[k] = pz_q[k] + $signed(a);
        end else begin
          px_d[k] = px_q[k] - (py_q[k] >>> k);
          py_d[k] = py_q[k] + (px_q[k] >>> k);
          pz_d[k] = pz_q[k] - $signed(a);
        end
        if (!ty_q[k][CW-1]) begin
          tx_d[k] = tx_q[k] + (ty_q[k] >>> k);
          ty_d[k] = ty_q[k] - (tx_q[k] >>> k);
          tz_d[k] = tz_q[k] + $signed(a);
        end else begin
          tx_d[k] = tx_q[k] - (ty_q[k] >>> k);
          ty_d[k] = ty_q[k] + (tx_q[k] >>> k);
          tz_d[k] = tz_q[k] - $signed(a);
        end
      end
    end
  endgenerate

  // multiply stage
  logic                                 mul_vld_q;
  logic signed [sptp_pkg::PRODW-1:0]    pprod_q, tprod_q;
  logic signed [sptp_pkg::ANGW-1:0]     pang, tang;
  logic signed [ZW-1:0]                 pzr, tzr;
  always_comb begin
    pzr  = pz_q[NCO] + ZW'(512);
    tzr  = tz_q[NCO] + ZW'(512);
    pang = pzr[ZW-1:10];
    tang = tzr[ZW-1:10];
  end

  // output stage
  logic                         out_vld_q;
  logic [11:0]                  pan_q, tilt_q;
  logic [1:0]                   flags_q;
  logic signed [sptp_pkg::PRODW-1:0] prr, trr;
  logic signed [sptp_pkg::POSW-1:0]  ppos, tpos, pcl, tcl;
  always_comb begin
    prr  = pprod_q + sptp_pkg::PRODW'(1 << 19);
    trr  = tprod_q + sptp_pkg::PRODW'(1 << 19);
    ppos = $signed({3'b0, pan_origin_q})
           + sptp_pkg::POSW'($signed(prr[sptp_pkg::PRODW-1:20]));
    tpos = $signed({3'b0, tilt_origin_q})
           + sptp_pkg::POSW'($signed(trr[sptp_pkg::PRODW-1:20]));
    pcl  = ppos;
    if (pcl < $signed({3'b0, pan_min_q})) pcl = $signed({3'b0, pan_min_q});
    if (pcl > $signed({3'b0, pan_max_q})) pcl = $signed({3'b0, pan_max_q});
    tcl  = tpos;
    if (tcl < $signed({3'b0, tilt_min_q})) tcl = $signed({3'b0, tilt_min_q});
    if (tcl > $signed({3'b0, tilt_max_q})) tcl = $signed({3'b0, tilt_max_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      mul_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
      for (int i = 0; i <= NSQ; i++) sq_vld_q[i] <= 1'b0;
      for (int i = 0; i <= NCO; i++) co_vld_q[i] <= 1'b0;
    end else if (en) begin
      in_vld_q    <= s_axis_tvalid;
      sq_vld_q[0] <= in_vld_q;
      for (int i = 0; i < NSQ; i++) sq_vld_q[i+1] <= sq_vld_q[i];
      co_vld_q[0] <= sq_vld_q[NSQ];
      for (int i = 0; i < NCO; i++) co_vld_q[i+1] <= co_vld_q[i];
      mul_vld_q   <= co_vld_q[NCO];
      out_vld_q   <= mul_vld_q;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_x_q <= s_axis_tdata[15:0];
      in_y_q <= s_axis_tdata[31:16];

      sq_r2_q[0]  <= sptp_pkg::R2W'(32'(in_x_q * in_x_q)) + DD;
      sq_rem_q[0] <= '0;
      sq_q_q[0]   <= '0;
      sq_x_q[0]   <= in_x_q;
      sq_y_q[0]   <= in_y_q;
      for (int i = 0; i < NSQ; i++) begin
        sq_r2_q[i+1]  <= sq_r2_q[i];
        sq_rem_q[i+1] <= sq_rem_d[i];
        sq_q_q[i+1]   <= sq_q_d[i];
        sq_x_q[i+1]   <= sq_x_q[i];
        sq_y_q[i+1]   <= sq_y_q[i];
      end

      px_q[0] <= $signed({6'b0, DIST, 24'b0});
      py_q[0] <= $signed({{6{sq_x_q[NSQ][15]}}, sq_x_q[NSQ], 24'b0});
      pz_q[0] <= '0;
      tx_q[0] <= $signed({5'b0, sq_q_q[NSQ], 16'b0});
      ty_q[0] <= $signed({{6{sq_y_q[NSQ][15]}}, sq_y_q[NSQ], 24'b0});
      tz_q[0] <= '0;
      for (int i = 0; i < NCO; i++) begin
        px_q[i+1] <= px_d[i];
        py_q[i+1] <= py_d[i];
        pz_q[i+1] <= pz_d[i];
        tx_q[i+1] <= tx_d[i];
        ty_q[i+1] <= ty_d[i];
        tz_q[i+1] <= tz_d[i];
      end

      pprod_q <= sptp_pkg::PRODW'(pang * $signed({1'b0, pan_scale_q}));
      tprod_q <= sptp_pkg::PRODW'(tang * $signed({1'b0, tilt_scale_q}));

      pan_q   <= pcl[11:0];
      tilt_q  <= tcl[11:0];
      flags_q <= {tcl != tpos, pcl != ppos};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, flags_q, tilt_q, pan_q};

endmodule
